### rtl/twrm_pkg.sv
// ----------------------------------------------------------------------------
// twrm_pkg
// Shared types and constants for the trailing time-window minimum block.
// ----------------------------------------------------------------------------
package twrm_pkg;

  localparam int TIME_BITS         = 40;
  localparam int VALUE_BITS        = 32;
  localparam int WINDOW_BITS       = 32;
  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(1000000);

  typedef struct packed {
    logic [TIME_BITS-1:0]         sample_time;
    logic signed [VALUE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] window_minimum;
    logic                         queue_overflow;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd_tail;
    logic rd_head;
    logic drop_tail;
    logic drop_head;
    logic set_ovf;
    logic push;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic back_ge;
    logic front_stale;
  } dp_sts_t;

endpackage

### rtl/twrm_ram.sv
// ----------------------------------------------------------------------------
// twrm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module twrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/twrm_ctrl.sv
// ----------------------------------------------------------------------------
// twrm_ctrl
// Sequencer: back discards, front drops, eviction, append and head read.
// ----------------------------------------------------------------------------
module twrm_ctrl
  import twrm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BACK_RD,
    S_BACK_CMP,
    S_FRONT_RD,
    S_FRONT_CMP,
    S_EVICT,
    S_WRITE,
    S_HEAD_RD,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_BACK_RD;
        end
      end
      S_BACK_RD: begin
        if (sts.empty) begin
          state_nxt = S_FRONT_RD;
        end else begin
          cmd.rd_tail = 1'b1;
          state_nxt   = S_BACK_CMP;
        end
      end
      S_BACK_CMP: begin
        if (sts.back_ge) begin
          cmd.drop_tail = 1'b1;
          state_nxt     = S_BACK_RD;
        end else begin
          state_nxt = S_FRONT_RD;
        end
      end
      S_FRONT_RD: begin
        if (sts.empty) begin
          state_nxt = S_EVICT;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_FRONT_CMP;
        end
      end
      S_FRONT_CMP: begin
        if (sts.front_stale) begin
          cmd.drop_head = 1'b1;
          state_nxt     = S_FRONT_RD;
        end else begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        // still full after stale drops: evict the oldest live entry
        if (sts.full) begin
          cmd.drop_head = 1'b1;
          cmd.set_ovf   = 1'b1;
        end
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.push  = 1'b1;
        state_nxt = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/twrm_dp.sv
// ----------------------------------------------------------------------------
// twrm_dp
// Ring queue pointers, entry RAM, window compares and result register.
// ----------------------------------------------------------------------------
module twrm_dp
  import twrm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  in_item_t               in_item,
  input  logic [WINDOW_BITS-1:0] window_length,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output out_item_t              out_item
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = IDX_W + 2;
  localparam int ENT_W  = TIME_BITS + VALUE_BITS;
  localparam int DIFF_W = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(QUEUE_DEPTH - 1);

  logic [IDX_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [TIME_BITS-1:0]         t_r;
  logic signed [VALUE_BITS-1:0] v_r;
  logic                         ovf_r;
  out_item_t                    out_r;

  logic [SUM_W-1:0]             push_sum, tail_sum;
  logic [IDX_W-1:0]             push_idx, tail_idx, head_inc;
  logic                         ram_re;
  logic [IDX_W-1:0]             ram_raddr;
  logic [ENT_W-1:0]             ram_rdata;
  logic [TIME_BITS-1:0]         rd_time;
  logic signed [VALUE_BITS-1:0] rd_value;
  logic [DIFF_W-1:0]            age;

  // ring arithmetic, both sums stay below twice the depth (the tail sum only while the queue is not empty)
  always_comb begin
    push_sum = SUM_W'(head_r) + SUM_W'(count_r);
    tail_sum = push_sum - SUM_W'(1);
    push_idx = (push_sum >= DEPTH_S) ? IDX_W'(push_sum - DEPTH_S) : IDX_W'(push_sum);
    tail_idx = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
    head_inc = (head_r == LAST_I) ? '0 : head_r + IDX_W'(1);
  end

  assign ram_re    = cmd.rd_tail || cmd.rd_head;
  assign ram_raddr = cmd.rd_tail ? tail_idx : head_r;

  twrm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (push_idx),
    .wdata ({t_r, v_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_time  = ram_rdata[ENT_W-1 -: TIME_BITS];
  assign rd_value = $signed(ram_rdata[VALUE_BITS-1:0]);
  assign age      = DIFF_W'(t_r - rd_time);

  always_comb begin
    sts.empty       = (count_r == '0);
    sts.full        = (count_r >= DEPTH_C);
    sts.back_ge     = (rd_value >= v_r);
    // equal to the window is still inside; newer entries are never stale
    sts.front_stale = (t_r > rd_time) && (age > DIFF_W'(window_length));
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.drop_tail) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.drop_head) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      t_r   <= in_item.sample_time;
      v_r   <= in_item.sample_value;
      ovf_r <= 1'b0;
    end else if (cmd.set_ovf) begin
      ovf_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_r.window_minimum <= rd_value;
      out_r.queue_overflow <= ovf_r;
    end
  end

  assign out_item = out_r;

endmodule

### rtl/time_window_running_min.sv
// ----------------------------------------------------------------------------
// time_window_running_min
// Trailing time-window minimum over a timestamped signed sample stream.
// ----------------------------------------------------------------------------
// Sequence: after an item is accepted, entries with a value not below it are
//   discarded at the back and stale entries dropped at the front, each queue
//   entry looked at taking a RAM read and then a compare on the single read
//   port; eviction, append, head read and result load follow in that order.
// Throughput: one item at a time, the next accepted in the cycle after the
//   result is loaded into the output register.
// Reset: queue empty, window length 1000000, no result pending.
// ----------------------------------------------------------------------------
module time_window_running_min
  import twrm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WINDOW_BITS-1:0] cfg_data
);

  logic [WINDOW_BITS-1:0] window_r;
  dp_cmd_t                cmd;
  dp_sts_t                sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_data;
    end
  end

  twrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  twrm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_item),
    .window_length (window_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_item      (out_item)
  );

endmodule
